FILE: sv/srv6sf_pkg.sv
package srv6sf_pkg;

  localparam logic [15:0] ETHERTYPE_IPV6   = 16'h86DD;
  localparam logic [7:0]  NEXT_HDR_ROUTING = 8'd43;
  localparam logic [7:0]  ACTION_END       = 8'd1;
  localparam int          MIN_FRAME_LEN    = 54;
  localparam int          SRH_END_LEN      = 62;

  typedef enum logic [1:0] {
    VERDICT_DROP = 2'd0,
    VERDICT_PASS = 2'd1,
    VERDICT_XMIT = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_JUDGE,
    S_SCAN,
    S_SEG,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic        en;
    logic [7:0]  idx;
    logic        half;
    logic [63:0] key;
    logic [7:0]  action;
    logic        valid;
  } tbl_wr_t;

  typedef struct packed {
    logic       done;
    logic       hit;
    logic [7:0] action;
  } lk_res_t;

endpackage

FILE: sv/srv6_end_segment_forwarder.sv
// Table writes and packet words are accepted only while idle, one word per cycle.
// After the last word: a judge state, a table scan (one slot per cycle
// through the key memories) and, for End, a segment fetch from the packet memory.
// Emission: one word per cycle from the packet memory.
// The receiver cannot stall; busy is high from the last word until the last result.
// Reset clears control state and slot valid bits; packet and key memories are not cleared.
module srv6_end_segment_forwarder #(
  parameter int BUFFER_WORDS  = 64,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [63:0] data_i,
  input  logic        last_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic [7:0]  entry_index_i,
  input  logic        key_half_i,
  input  logic [7:0]  entry_action_i,
  input  logic        entry_valid_i,
  output logic        out_valid_o,
  output logic [63:0] out_data_o,
  output logic        out_last_o,
  output logic [3:0]  out_valid_bytes_o,
  output logic [1:0]  verdict_o,
  output logic        too_long_o
);
  import srv6sf_pkg::*;

  localparam int AW = $clog2(BUFFER_WORDS);
  localparam int CW = $clog2(BUFFER_WORDS + 1);
  localparam int LW = $clog2(BUFFER_WORDS * 8 + 1);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] len_q, len_d;
  logic [3:0]    tail_q, tail_d;
  logic          ovf_q, ovf_d;
  logic [63:0]   w0_q, w0_d, w1_q, w1_d, w5_q, w5_d;
  logic          eth_ok_q, eth_ok_d, nh_ok_q, nh_ok_d;
  logic [15:0]   k4_q, k4_d;
  logic [47:0]   k6_q, k6_d;
  logic [7:0]    sl_q, sl_d;
  verdict_e      verdict_q, verdict_d;
  logic [1:0]    seg_cnt_q, seg_cnt_d;
  logic [15:0]   s0_q, s0_d;
  logic [63:0]   s1_q, s1_d;
  logic [47:0]   s2_q, s2_d;
  logic [CW-1:0] rd_k_q, rd_k_d, pk_q, pk_d;
  logic          pend_q, pend_d;
  logic          ov_q, ov_d;
  logic [63:0]   od_q, od_d;
  logic          ol_q, ol_d;
  logic [3:0]    ovb_q, ovb_d;
  logic [1:0]    over_q, over_d;
  logic          otl_q, otl_d;

  logic          acc;
  logic [3:0]    vb;
  logic          we;
  logic [AW-1:0] raddr;
  logic [63:0]   rd;
  logic [63:0]   mod;
  logic          scan_start;
  lk_res_t       lk;
  tbl_wr_t       wr;
  logic [12:0]   seg_end;
  logic [9:0]    seg_addr;
  logic          fin;

  assign acc = start && (state_q == S_IDLE);
  assign vb  = ((valid_bytes_i == 4'd0) || (valid_bytes_i > 4'd8)) ? 4'd8 : valid_bytes_i;

  assign wr.en     = acc && mode_i;
  assign wr.idx    = entry_index_i;
  assign wr.half   = key_half_i;
  assign wr.key    = data_i;
  assign wr.action = entry_action_i;
  assign wr.valid  = entry_valid_i;

  srv6sf_ram #(.WIDTH(64), .DEPTH(BUFFER_WORDS), .AW(AW)) u_packet (
    .clk_i, .we_i(we), .waddr_i(cnt_q[AW-1:0]), .wdata_i(data_i),
    .raddr_i(raddr), .rdata_o(rd)
  );

  srv6sf_lookup #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_lookup (
    .clk_i, .rst_ni, .wr_i(wr), .scan_start_i(scan_start),
    .key_hi_i({k4_q, w5_q[63:16]}), .key_lo_i({w5_q[15:0], k6_q}), .res_o(lk)
  );

  assign seg_end  = 13'(SRH_END_LEN) + 13'({sl_q, 4'b0000});
  assign seg_addr = 10'd5 + {1'b0, sl_q, 1'b0} + 10'(seg_cnt_q);
  assign fin      = (pk_q + 1'b1) == cnt_q;

  always_comb begin
    mod = rd;
    if (verdict_q == VERDICT_XMIT) begin
      if (pk_q == CW'(0)) begin
        mod = {w0_q[15:0], w1_q[63:32], w0_q[63:48]};
      end else if (pk_q == CW'(1)) begin
        mod = {w0_q[47:16], w1_q[31:0]};
      end else if (pk_q == CW'(4)) begin
        mod = {rd[63:16], s0_q};
      end else if (pk_q == CW'(5)) begin
        mod = s1_q;
      end else if (pk_q == CW'(6)) begin
        mod = {s2_q, rd[15:0]};
      end else if (pk_q == CW'(7)) begin
        mod = {rd[63:56], sl_q - 8'd1, rd[47:0]};
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    tail_d     = tail_q;
    ovf_d      = ovf_q;
    w0_d       = w0_q;
    w1_d       = w1_q;
    w5_d       = w5_q;
    eth_ok_d   = eth_ok_q;
    nh_ok_d    = nh_ok_q;
    k4_d       = k4_q;
    k6_d       = k6_q;
    sl_d       = sl_q;
    verdict_d  = verdict_q;
    seg_cnt_d  = seg_cnt_q;
    s0_d       = s0_q;
    s1_d       = s1_q;
    s2_d       = s2_q;
    rd_k_d     = rd_k_q;
    pk_d       = pk_q;
    pend_d     = 1'b0;
    ov_d       = 1'b0;
    od_d       = od_q;
    ol_d       = ol_q;
    ovb_d      = ovb_q;
    over_d     = over_q;
    otl_d      = otl_q;
    we         = 1'b0;
    raddr      = '0;
    scan_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        rd_k_d = '0;
        if (acc && !mode_i) begin
          if (cnt_q < CW'(BUFFER_WORDS)) begin
            we     = 1'b1;
            cnt_d  = cnt_q + 1'b1;
            len_d  = LW'({cnt_q, 3'b000}) + LW'(vb);
            tail_d = vb;
            if (cnt_q == CW'(0)) w0_d = data_i;
            if (cnt_q == CW'(1)) begin
              w1_d     = data_i;
              eth_ok_d = (data_i[31:16] == ETHERTYPE_IPV6);
            end
            if (cnt_q == CW'(2)) nh_ok_d = (data_i[31:24] == NEXT_HDR_ROUTING);
            if (cnt_q == CW'(4)) k4_d = data_i[15:0];
            if (cnt_q == CW'(5)) w5_d = data_i;
            if (cnt_q == CW'(6)) k6_d = data_i[63:16];
            if (cnt_q == CW'(7)) sl_d = data_i[55:48];
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) state_d = S_JUDGE;
        end
      end
      S_JUDGE: begin
        if (ovf_q || (len_q < LW'(MIN_FRAME_LEN))) begin
          verdict_d = VERDICT_DROP;
          state_d   = S_EMIT;
        end else if (!(eth_ok_q && nh_ok_q)) begin
          verdict_d = VERDICT_PASS;
          state_d   = S_EMIT;
        end else begin
          scan_start = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (lk.done) begin
          state_d   = S_EMIT;
          verdict_d = VERDICT_DROP;
          if (!lk.hit) begin
            verdict_d = VERDICT_PASS;
          end else if ((lk.action == ACTION_END) &&
                       (len_q >= LW'(SRH_END_LEN)) && (sl_q != 8'd0) &&
                       (seg_end <= 13'(len_q))) begin
            seg_cnt_d = '0;
            state_d   = S_SEG;
          end
        end
      end
      S_SEG: begin
        raddr     = seg_addr[AW-1:0];
        seg_cnt_d = seg_cnt_q + 2'd1;
        if (seg_cnt_q == 2'd1) s0_d = rd[15:0];
        if (seg_cnt_q == 2'd2) s1_d = rd;
        if (seg_cnt_q == 2'd3) begin
          s2_d      = rd[63:16];
          verdict_d = VERDICT_XMIT;
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (rd_k_q < cnt_q) begin
          raddr  = rd_k_q[AW-1:0];
          pend_d = 1'b1;
          pk_d   = rd_k_q;
          rd_k_d = rd_k_q + 1'b1;
        end
        if (pend_q) begin
          ov_d   = 1'b1;
          od_d   = mod;
          ol_d   = fin;
          ovb_d  = fin ? tail_q : 4'd8;
          over_d = verdict_q;
          otl_d  = ovf_q;
          if (fin) begin
            pend_d  = 1'b0;
            state_d = S_IDLE;
            cnt_d   = '0;
            len_d   = '0;
            tail_d  = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      len_q     <= '0;
      tail_q    <= '0;
      ovf_q     <= 1'b0;
      verdict_q <= VERDICT_DROP;
      seg_cnt_q <= '0;
      rd_k_q    <= '0;
      pk_q      <= '0;
      pend_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      tail_q    <= tail_d;
      ovf_q     <= ovf_d;
      verdict_q <= verdict_d;
      seg_cnt_q <= seg_cnt_d;
      rd_k_q    <= rd_k_d;
      pk_q      <= pk_d;
      pend_q    <= pend_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w0_q     <= w0_d;
    w1_q     <= w1_d;
    w5_q     <= w5_d;
    eth_ok_q <= eth_ok_d;
    nh_ok_q  <= nh_ok_d;
    k4_q     <= k4_d;
    k6_q     <= k6_d;
    sl_q     <= sl_d;
    s0_q     <= s0_d;
    s1_q     <= s1_d;
    s2_q     <= s2_d;
    od_q     <= od_d;
    ol_q     <= ol_d;
    ovb_q    <= ovb_d;
    over_q   <= over_d;
    otl_q    <= otl_d;
  end

  assign busy              = (state_q != S_IDLE);
  assign out_valid_o       = ov_q;
  assign out_data_o        = od_q;
  assign out_last_o        = ol_q;
  assign out_valid_bytes_o = ovb_q;
  assign verdict_o         = over_q;
  assign too_long_o        = otl_q;

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(state_q == S_EMIT))
    else $error("word emitted outside emission");

  a_long_is_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && too_long_o) |-> (verdict_o == VERDICT_DROP))
    else $error("overflowed frame not dropped");

  a_seg_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEG) |-> (!ovf_q && (cnt_q >= CW'(8))))
    else $error("segment fetch on invalid frame");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |-> (state_q == S_IDLE))
    else $error("last word while still busy");

endmodule

FILE: sv/srv6sf_ram.sv
module srv6sf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/srv6sf_lookup.sv
module srv6sf_lookup #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srv6sf_pkg::tbl_wr_t  wr_i,
  input  logic                 scan_start_i,
  input  logic [63:0]          key_hi_i,
  input  logic [63:0]          key_lo_i,
  output srv6sf_pkg::lk_res_t  res_o
);
  import srv6sf_pkg::*;

  localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic                     scanning_q, scanning_d;
  logic [TW:0]              cnt_q, cnt_d;
  logic                     pend_q, pend_d;
  logic [TW-1:0]            pslot_q, pslot_d;
  logic [TW-1:0]            raddr;
  logic                     wr_ok;
  logic [63:0]              ku_rd, kl_rd;
  logic [7:0]               act_rd;
  logic                     hit;
  logic                     last_slot;

  assign wr_ok = wr_i.en && ({1'b0, wr_i.idx} < 9'(TABLE_ENTRIES));

  srv6sf_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES), .AW(TW)) u_key_upper (
    .clk_i, .we_i(wr_ok && !wr_i.half), .waddr_i(wr_i.idx[TW-1:0]),
    .wdata_i(wr_i.key), .raddr_i(raddr), .rdata_o(ku_rd)
  );

  srv6sf_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES), .AW(TW)) u_key_lower (
    .clk_i, .we_i(wr_ok && wr_i.half), .waddr_i(wr_i.idx[TW-1:0]),
    .wdata_i(wr_i.key), .raddr_i(raddr), .rdata_o(kl_rd)
  );

  srv6sf_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES), .AW(TW)) u_action (
    .clk_i, .we_i(wr_ok), .waddr_i(wr_i.idx[TW-1:0]),
    .wdata_i(wr_i.action), .raddr_i(raddr), .rdata_o(act_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_ok) begin
      valid_q[wr_i.idx[TW-1:0]] <= wr_i.valid;
    end
  end

  assign hit       = valid_q[pslot_q] && (ku_rd == key_hi_i) && (kl_rd == key_lo_i);
  assign last_slot = (pslot_q == TW'(TABLE_ENTRIES - 1));

  always_comb begin
    scanning_d   = scanning_q;
    cnt_d        = cnt_q;
    pend_d       = 1'b0;
    pslot_d      = pslot_q;
    raddr        = cnt_q[TW-1:0];
    res_o.done   = 1'b0;
    res_o.hit    = hit;
    res_o.action = act_rd;
    if (scan_start_i) begin
      scanning_d = 1'b1;
      cnt_d      = '0;
    end else if (scanning_q) begin
      if (pend_q && (hit || last_slot)) begin
        res_o.done = 1'b1;
        scanning_d = 1'b0;
      end else if (cnt_q < (TW+1)'(TABLE_ENTRIES)) begin
        pend_d  = 1'b1;
        pslot_d = cnt_q[TW-1:0];
        cnt_d   = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scanning_q <= 1'b0;
      cnt_q      <= '0;
      pend_q     <= 1'b0;
      pslot_q    <= '0;
    end else begin
      scanning_q <= scanning_d;
      cnt_q      <= cnt_d;
      pend_q     <= pend_d;
      pslot_q    <= pslot_d;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import srv6sf_pkg::*;

  typedef struct packed {
    logic [63:0] data;
    logic        last;
    logic [3:0]  vb;
    logic [1:0]  verdict;
    logic        too_long;
  } out_word_t;

  typedef struct {
    int       len;
    int       dst_sel;
    bit       ipv6;
    bit       rh;
    int       sl;
    bit       odd_mid;
    int       typed;
  } frame_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        mode_i = 1'b0;
  logic [63:0] data_i = '0;
  logic        last_i = 1'b0;
  logic [3:0]  valid_bytes_i = 4'd8;
  logic [7:0]  entry_index_i = '0;
  logic        key_half_i = 1'b0;
  logic [7:0]  entry_action_i = '0;
  logic        entry_valid_i = 1'b0;
  logic        out_valid_o;
  logic [63:0] out_data_o;
  logic        out_last_o;
  logic [3:0]  out_valid_bytes_o;
  logic [1:0]  verdict_o;
  logic        too_long_o;

  srv6_end_segment_forwarder DUT (.*);

  always #5 clk_i = ~clk_i;

  out_word_t   emit_q[$];
  logic [63:0] frame_mem[0:63];
  int          words_held;
  int          tail_vb;
  bit          overflow;
  logic [63:0] tbl_hi[0:255];
  logic [63:0] tbl_lo[0:255];
  logic [7:0]  tbl_act[0:255];
  bit          tbl_vld[0:255];
  logic [127:0] key_pool[0:7];
  logic [7:0]  frame_bytes[0:1023];
  int          typed_verdict = -1;
  int          errors = 0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          burst_left = 0;

  function automatic logic [7:0] get_b(int p);
    return frame_mem[6'(p >> 3)][56 - 8 * (p & 7) +: 8];
  endfunction

  task automatic put_b(int p, logic [7:0] v);
    frame_mem[6'(p >> 3)][56 - 8 * (p & 7) +: 8] = v;
  endtask

  function automatic logic [63:0] get_w64(int p);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) r = {r[55:0], get_b(p + i)};
    return r;
  endfunction

  task automatic judge_frame(output verdict_e v);
    int len;
    int slot;
    int sl;
    int seg;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0] a;
    len = (words_held - 1) * 8 + tail_vb;
    slot = -1;
    if (len < MIN_FRAME_LEN) begin
      v = VERDICT_DROP;
      return;
    end
    if ({get_b(12), get_b(13)} != ETHERTYPE_IPV6 || get_b(20) != NEXT_HDR_ROUTING) begin
      v = VERDICT_PASS;
      return;
    end
    hi = get_w64(38);
    lo = get_w64(46);
    for (int s = 0; s < 256; s++) begin
      if (slot < 0 && tbl_vld[8'(s)] && tbl_hi[8'(s)] == hi && tbl_lo[8'(s)] == lo)
        slot = s;
    end
    if (slot < 0) begin
      v = VERDICT_PASS;
      return;
    end
    if (tbl_act[8'(slot)] != ACTION_END || len < SRH_END_LEN) begin
      v = VERDICT_DROP;
      return;
    end
    sl = get_b(57);
    if (sl == 0 || SRH_END_LEN + 16 * sl > len) begin
      v = VERDICT_DROP;
      return;
    end
    sl = sl - 1;
    for (int i = 0; i < 6; i++) begin
      a = get_b(i);
      put_b(i, get_b(6 + i));
      put_b(6 + i, a);
    end
    put_b(57, sl[7:0]);
    seg = SRH_END_LEN + 16 * sl;
    for (int i = 0; i < 16; i++) put_b(38 + i, get_b(seg + i));
    v = VERDICT_XMIT;
  endtask

  task automatic absorb_word();
    int vb;
    verdict_e v;
    out_word_t w;
    if (mode_i) begin
      if (key_half_i) tbl_lo[entry_index_i] = data_i;
      else tbl_hi[entry_index_i] = data_i;
      tbl_act[entry_index_i] = entry_action_i;
      tbl_vld[entry_index_i] = entry_valid_i;
      return;
    end
    vb = int'(valid_bytes_i);
    if (vb == 0 || vb > 8) vb = 8;
    if (words_held < 64) begin
      frame_mem[6'(words_held)] = data_i;
      words_held++;
      tail_vb = vb;
    end else begin
      overflow = 1'b1;
    end
    if (!last_i) return;
    if (overflow) v = VERDICT_DROP;
    else judge_frame(v);
    if (typed_verdict >= 0) v = verdict_e'(typed_verdict);
    for (int k = 0; k < words_held; k++) begin
      w.data = frame_mem[6'(k)];
      w.last = (k + 1 == words_held);
      w.vb = w.last ? 4'(tail_vb) : 4'd8;
      w.verdict = v;
      w.too_long = overflow;
      emit_q.push_back(w);
    end
    words_held = 0;
    tail_vb = 0;
    overflow = 1'b0;
  endtask

  task automatic send_word(bit m, logic [63:0] d, bit l, logic [3:0] vb,
                           logic [7:0] idx, bit half, logic [7:0] act, bit vld);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk_i);
          start <= 1'b0;
        end
      end
    end
    burst_left--;
    @(negedge clk_i);
    start <= 1'b1;
    mode_i <= m;
    data_i <= d;
    last_i <= l;
    valid_bytes_i <= vb;
    entry_index_i <= idx;
    key_half_i <= half;
    entry_action_i <= act;
    entry_valid_i <= vld;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    absorb_word();
    items_sent++;
  endtask

  task automatic write_slot(logic [7:0] idx, logic [127:0] key, logic [7:0] act, bit vld);
    send_word(1'b1, key[127:64], 1'($urandom_range(0, 1)), 4'($urandom), idx, 1'b0, act,
              vld);
    send_word(1'b1, key[63:0], 1'($urandom_range(0, 1)), 4'($urandom), idx, 1'b1, act,
              vld);
  endtask

  task automatic send_frame(frame_row_t r);
    int n;
    int vb;
    logic [63:0] d;
    logic [127:0] dst;
    for (int i = 0; i < 1024; i++) frame_bytes[10'(i)] = 8'($urandom);
    dst = (r.dst_sel >= 0) ? key_pool[3'(r.dst_sel)] : {$urandom, $urandom, $urandom, $urandom};
    if (r.ipv6) {frame_bytes[12], frame_bytes[13]} = ETHERTYPE_IPV6;
    else if ({frame_bytes[12], frame_bytes[13]} == ETHERTYPE_IPV6) frame_bytes[13] = 8'h00;
    if (r.rh) frame_bytes[20] = NEXT_HDR_ROUTING;
    else if (frame_bytes[20] == NEXT_HDR_ROUTING) frame_bytes[20] = 8'd6;
    for (int i = 0; i < 16; i++) frame_bytes[10'(38 + i)] = dst[127 - 8 * i -: 8];
    frame_bytes[57] = 8'(r.sl);
    n = (r.len + 7) / 8;
    for (int w = 0; w < n; w++) begin
      for (int i = 0; i < 8; i++) d[63 - 8 * i -: 8] = frame_bytes[10'(8 * w + i)];
      if (w + 1 == n) begin
        vb = r.len - 8 * (n - 1);
        if (vb == 8) begin
          case ($urandom_range(0, 3))
            0: vb = 0;
            1: vb = $urandom_range(9, 15);
            default: vb = 8;
          endcase
        end
      end else begin
        vb = r.odd_mid ? $urandom_range(0, 15) : 8;
      end
      send_word(1'b0, d, w + 1 == n, 4'(vb), 8'($urandom), 1'($urandom_range(0, 1)),
                8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (emit_q.size() != 0 || busy) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && out_valid_o) begin
      if (emit_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data_o);
      end else begin
        e = emit_q.pop_front();
        if (out_data_o !== e.data || out_last_o !== e.last ||
            out_valid_bytes_o !== e.vb || verdict_o !== e.verdict ||
            too_long_o !== e.too_long) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h l%0d vb%0d v%0d t%0d got %h l%0d vb%0d v%0d t%0d",
                     e.data, e.last, e.vb, e.verdict, e.too_long, out_data_o,
                     out_last_o, out_valid_bytes_o, verdict_o, too_long_o);
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    frame_row_t rows[$];
    frame_row_t r;
    int nseg;
    words_held = 0;
    tail_vb = 0;
    overflow = 1'b0;
    for (int i = 0; i < 256; i++) tbl_vld[8'(i)] = 1'b0;
    for (int i = 0; i < 8; i++) key_pool[3'(i)] = {$urandom, $urandom, $urandom, $urandom};
    key_pool[6] = '1;
    key_pool[7] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_slot(8'd0, key_pool[0], ACTION_END, 1'b1);
    write_slot(8'd255, key_pool[1], ACTION_END, 1'b1);
    write_slot(8'd5, key_pool[2], 8'hFF, 1'b1);
    write_slot(8'd3, key_pool[3], ACTION_END, 1'b1);
    write_slot(8'd9, key_pool[3], 8'd7, 1'b1);
    write_slot(8'd10, key_pool[4], ACTION_END, 1'b1);
    write_slot(8'd10, key_pool[4], ACTION_END, 1'b0);
    write_slot(8'd128, key_pool[6], ACTION_END, 1'b1);
    write_slot(8'd129, key_pool[7], 8'h00, 1'b1);

    rows.push_back('{8, 0, 1, 1, 1, 0, VERDICT_DROP});
    rows.push_back('{53, 0, 1, 1, 1, 0, VERDICT_DROP});
    rows.push_back('{56, 0, 0, 1, 1, 0, VERDICT_PASS});
    rows.push_back('{56, 0, 1, 0, 1, 0, VERDICT_PASS});
    rows.push_back('{56, -1, 1, 1, 1, 0, VERDICT_PASS});
    rows.push_back('{56, 4, 1, 1, 1, 0, VERDICT_PASS});
    rows.push_back('{56, 2, 1, 1, 1, 0, VERDICT_DROP});
    rows.push_back('{56, 7, 1, 1, 1, 0, VERDICT_DROP});
    rows.push_back('{58, 0, 1, 1, 1, 0, VERDICT_DROP});
    rows.push_back('{64, 0, 1, 1, 0, 0, VERDICT_DROP});
    rows.push_back('{78, 0, 1, 1, 2, 0, VERDICT_DROP});
    rows.push_back('{54, 0, 1, 1, 1, 0, -1});
    rows.push_back('{78, 0, 1, 1, 1, 0, -1});
    rows.push_back('{94, 1, 1, 1, 2, 1, -1});
    rows.push_back('{94, 3, 1, 1, 2, 0, -1});
    rows.push_back('{64, 6, 1, 1, 255, 0, -1});
    rows.push_back('{126, 6, 1, 1, 4, 0, -1});
    rows.push_back('{520, 0, 1, 1, 1, 0, VERDICT_DROP});
    foreach (rows[i]) begin
      typed_verdict = rows[i].typed;
      send_frame(rows[i]);
    end
    typed_verdict = -1;
    wait_drained();

    while (items_sent < 270) begin
      if ($urandom_range(0, 7) == 0) begin
        write_slot(8'($urandom), key_pool[3'($urandom)],
                   ($urandom_range(0, 2) != 0) ? ACTION_END : 8'($urandom),
                   $urandom_range(0, 4) != 0);
      end
      nseg = $urandom_range(1, 4);
      r.len = SRH_END_LEN + 16 * nseg + $urandom_range(0, 9);
      r.dst_sel = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 7) : -1;
      r.ipv6 = $urandom_range(0, 9) != 0;
      r.rh = $urandom_range(0, 9) != 0;
      r.sl = $urandom_range(0, nseg + 1);
      r.odd_mid = $urandom_range(0, 7) == 0;
      r.typed = -1;
      case ($urandom_range(0, 9))
        0: r.len = $urandom_range(1, 70);
        1: r.len = $urandom_range(120, 200);
        default: ;
      endcase
      if (r.len > 512 && $urandom_range(0, 1)) r.len = 512;
      send_frame(r);
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (emit_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/srv6sf_pkg.sv
sv/srv6sf_ram.sv
sv/srv6sf_lookup.sv
sv/srv6_end_segment_forwarder.sv
tb/sv/tb_top.sv
